// ----- design/pfdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfdc_pkg
// Shared constants, codes and controller/datapath interface types for the
// filtered-derivative PID core.
// ----------------------------------------------------------------------------
package pfdc_pkg;

  // Default value format: signed Q12.12.
  localparam int VALUE_WIDTH_DEF   = 24;
  localparam int FRACTION_BITS_DEF = 12;

  // Fixed field and state widths.
  localparam int CMD_W     = 2;
  localparam int DT_W      = 16;
  localparam int ACC_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Divider geometry: signed numerator, denominator tau + dt, quotient bits
  // kept before the result is known to saturate the filter state.
  localparam int NUM_W  = 52;
  localparam int DEN_W  = DT_W + 1;
  localparam int QCAP_W = NUM_W - 1 - DEN_W;

  // Wide work width for saturation compares.
  localparam int WIDE_W = 72;

  // Reset values.
  localparam logic [DT_W-1:0] TAU_RESET         = 16'd174;
  localparam int              LIMIT_RESET_UNITS = 200;

  // Integral increment magnitude bound, as a power of two.
  localparam int INC_LIMIT_LOG2 = 40;
  localparam int T_W            = INC_LIMIT_LOG2 + 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_POSITION = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RATE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TAU  = 3'd4;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic clear;
    logic mul1;
    logic mul2;
    logic mul3;
    logic integ;
    logic div_step;
    logic fr_upd;
    logic d_mul;
    logic d_rnd;
    logic sum;
    logic fin;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_req;
    logic d_en;
  } ctl_sts_t;

endpackage

// ----- design/pfdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfdc_ctrl
// Sequencer for one PID update: steps the datapath, runs the divider count
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module pfdc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pfdc_pkg::ctl_sts_t  sts,
  output pfdc_pkg::ctl_cmd_t  cmd
);
  import pfdc_pkg::*;

  localparam int CNT_W = $clog2(QCAP_W);

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_CLR   = 13'b0000000000010,
    ST_MUL1  = 13'b0000000000100,
    ST_MUL2  = 13'b0000000001000,
    ST_MUL3  = 13'b0000000010000,
    ST_INTEG = 13'b0000000100000,
    ST_DIV   = 13'b0000001000000,
    ST_FRUPD = 13'b0000010000000,
    ST_DMUL  = 13'b0000100000000,
    ST_DRND  = 13'b0001000000000,
    ST_SUM   = 13'b0010000000000,
    ST_FIN   = 13'b0100000000000,
    ST_OUT   = 13'b1000000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Next state and step commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.clear_req ? ST_CLR : ST_MUL1;
        end
      end
      ST_CLR: begin
        cmd.clear = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ = 1'b1;
        cnt_nxt   = CNT_W'(QCAP_W - 1);
        state_nxt = sts.d_en ? ST_DIV : ST_SUM;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FRUPD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FRUPD: begin
        cmd.fr_upd = 1'b1;
        state_nxt  = ST_DMUL;
      end
      ST_DMUL: begin
        cmd.d_mul = 1'b1;
        state_nxt = ST_DRND;
      end
      ST_DRND: begin
        cmd.d_rnd = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output beat valid: set on load, dropped once taken.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- design/pfdc_datapath.sv -----
// ----------------------------------------------------------------------------
// pfdc_datapath
// Configuration registers, loop state, multipliers, the bit-serial filter
// divider and the output register of the PID core.
// ----------------------------------------------------------------------------
module pfdc_datapath #(
  parameter int VALUE_WIDTH   = pfdc_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = pfdc_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_write_en,
  input  logic [pfdc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [((VALUE_WIDTH > pfdc_pkg::DT_W) ? VALUE_WIDTH : pfdc_pkg::DT_W)-1:0]
                                              cfg_wdata,
  input  logic [pfdc_pkg::CMD_W-1:0]          in_command,
  input  logic signed [VALUE_WIDTH-1:0]       in_setpoint,
  input  logic signed [VALUE_WIDTH-1:0]       in_measured,
  input  logic signed [VALUE_WIDTH-1:0]       in_measured_rate,
  input  logic [pfdc_pkg::DT_W-1:0]           in_time_step,
  output logic signed [VALUE_WIDTH-1:0]       out_drive,
  output logic                                out_saturated,
  input  pfdc_pkg::ctl_cmd_t                  cmd,
  output pfdc_pkg::ctl_sts_t                  sts
);
  import pfdc_pkg::*;

  localparam int W      = VALUE_WIDTH;
  localparam int F      = FRACTION_BITS;
  localparam int ERR_W  = W + 1;
  localparam int P_W    = 2 * W + 1;
  localparam int MOP_W  = ACC_W + 2;
  localparam int MT_W   = MOP_W + DT_W + 1;
  localparam int INC_W  = T_W + DT_W + 1;
  localparam int DP_W   = ACC_W + W;
  localparam int SUM_W  = W + 40;
  localparam int LIM_W  = W - 1;

  localparam longint LIM_FULL  = longint'(LIMIT_RESET_UNITS) << F;
  localparam longint LIM_MAX   = (longint'(1) << (W - 1)) - 1;
  localparam logic [LIM_W-1:0] LIM_RESET =
    LIM_W'((LIM_FULL > LIM_MAX) ? LIM_MAX : LIM_FULL);

  localparam logic signed [P_W-1:0]   P_HALF   = P_W'(longint'(1) << (F - 1));
  localparam logic signed [INC_W-1:0] INC_HALF = INC_W'(longint'(1) << 15);
  localparam logic signed [DP_W-1:0]  D_HALF   = DP_W'(longint'(1) << (F - 1));
  localparam logic signed [WIDE_W-1:0] T_LIM   =
    WIDE_W'(longint'(1) << INC_LIMIT_LOG2);
  localparam logic signed [WIDE_W-1:0] ACC_MAX =
    WIDE_W'((longint'(1) << (ACC_W - 1)) - 1);

  // Saturate a wide signed value to the 32-bit accumulator range.
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] x);
    logic signed [ACC_W-1:0] r;
    if (x > ACC_MAX) begin
      r = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (x < -ACC_MAX - 1) begin
      r = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      r = x[ACC_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [LIM_W-1:0]    limit_r;
  logic [DT_W-1:0]     tau_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      limit_r  <= LIM_RESET;
      tau_r    <= TAU_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_GAIN_P:      gain_p_r <= cfg_wdata[W-1:0];
        REG_GAIN_I:      gain_i_r <= cfg_wdata[W-1:0];
        REG_GAIN_D:      gain_d_r <= cfg_wdata[W-1:0];
        REG_DRIVE_LIMIT: limit_r  <= cfg_wdata[LIM_W-1:0];
        REG_FILTER_TAU:  tau_r    <= cfg_wdata[DT_W-1:0];
        default: ;
      endcase
    end
  end

  // Loop state.
  logic signed [ACC_W-1:0] integral_r, fr_r;
  logic signed [W-1:0]     pp_r;
  logic                    ie_r;

  // Captured beat and intermediate results.
  logic                    rate_cmd_r;
  logic signed [W-1:0]     ms_r, rate_r;
  logic [DT_W-1:0]         dt_r;
  logic signed [ERR_W-1:0] err_r, posdiff_r;
  logic signed [P_W-1:0]   p_prod_r, i_prod_r, p_r;
  logic signed [MOP_W-1:0] mop_r;
  logic signed [T_W-1:0]   t_r;
  logic signed [MT_W-1:0]  mterm_r;
  logic signed [INC_W-1:0] inc_prod_r;
  logic signed [NUM_W-1:0] num_r;
  logic signed [DP_W-1:0]  d_prod_r, d_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [W-1:0]     res_drive_r, out_drive_r;
  logic                    res_sat_r, out_sat_r;

  // Divider registers.
  logic [DEN_W-1:0]  rem_r, den_r;
  logic [QCAP_W-1:0] nlow_r, q_r;
  logic              qovf_r, qneg_r;

  // Combinational helpers.
  logic signed [P_W-1:0]    i_rnd;
  logic signed [WIDE_W-1:0] i_ext;
  logic signed [T_W-1:0]    t_nxt;
  logic signed [DT_W:0]     dt_s;
  logic signed [NUM_W-1:0]  num_abs;
  logic [DEN_W-1:0]         num_hi, den_nxt;
  logic [DEN_W:0]           trial;
  logic                     ge;
  logic [QCAP_W-1:0]        qmag;
  logic signed [QCAP_W+1:0] qs;
  logic signed [SUM_W-1:0]  lim_s;
  logic                     ovf;

  assign dt_s = $signed({1'b0, dt_r});

  // Increment rounding and limit.
  always_comb begin
    i_rnd = (i_prod_r + P_HALF) >>> F;
    i_ext = WIDE_W'(i_rnd);
    if (i_ext > T_LIM) begin
      t_nxt = T_W'(T_LIM);
    end else if (i_ext < -T_LIM) begin
      t_nxt = T_W'(-T_LIM);
    end else begin
      t_nxt = T_W'(i_ext);
    end
  end

  // Divider set-up and one restoring step.
  always_comb begin
    num_abs = (num_r < 0) ? -num_r : num_r;
    num_hi  = num_abs[NUM_W-2:QCAP_W];
    den_nxt = {1'b0, tau_r} + {1'b0, dt_r};
    trial   = {rem_r, nlow_r[QCAP_W-1]};
    ge      = (trial >= {1'b0, den_r});
    qmag    = qovf_r ? '1 : q_r;
    qs      = qneg_r ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
  end

  // Output clamp.
  always_comb begin
    lim_s = SUM_W'($signed({1'b0, limit_r}));
    ovf   = (sum_r > lim_s) || (sum_r < -lim_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      fr_r       <= '0;
      pp_r       <= '0;
      ie_r       <= 1'b1;
    end else begin
      // Clear command zeroes the loop state and re-enables the integral.
      if (cmd.clear) begin
        integral_r <= '0;
        fr_r       <= '0;
        pp_r       <= '0;
        ie_r       <= 1'b1;
      end
      // Integral update, frozen while winding up.
      if (cmd.integ && ie_r) begin
        integral_r <= sat_acc(WIDE_W'(integral_r) +
                              WIDE_W'((inc_prod_r + INC_HALF) >>> DT_W));
      end
      if (cmd.integ && sts.d_en && !rate_cmd_r) begin
        pp_r <= ms_r;
      end
      // Filter state update from the quotient.
      if (cmd.fr_upd) begin
        fr_r <= sat_acc(WIDE_W'(fr_r) + WIDE_W'(qs));
      end
      if (cmd.fin) begin
        ie_r <= !ovf || ((sum_r < 0) != (err_r < 0));
      end
    end
  end

  // Arithmetic steps; payload registers need no reset.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      rate_cmd_r <= (in_command == CMD_RATE);
      ms_r       <= in_measured;
      rate_r     <= in_measured_rate;
      dt_r       <= in_time_step;
      err_r      <= ERR_W'(in_setpoint) - ERR_W'(in_measured);
    end
    if (cmd.mul1) begin
      p_prod_r  <= P_W'(gain_p_r) * P_W'(err_r);
      i_prod_r  <= P_W'(gain_i_r) * P_W'(err_r);
      posdiff_r <= ERR_W'(pp_r) - ERR_W'(ms_r);
      mop_r     <= rate_cmd_r ? (-MOP_W'(rate_r) - MOP_W'(fr_r)) : -MOP_W'(fr_r);
    end
    if (cmd.mul2) begin
      p_r     <= (p_prod_r + P_HALF) >>> F;
      t_r     <= t_nxt;
      mterm_r <= MT_W'(mop_r) * MT_W'(dt_s);
    end
    if (cmd.mul3) begin
      inc_prod_r <= INC_W'(t_r) * INC_W'(dt_s);
      num_r      <= NUM_W'(mterm_r) +
                    (rate_cmd_r ? '0 : (NUM_W'(posdiff_r) <<< DT_W));
    end
    if (cmd.integ) begin
      d_r    <= '0;
      den_r  <= den_nxt;
      rem_r  <= num_hi;
      nlow_r <= num_abs[QCAP_W-1:0];
      qovf_r <= (num_hi >= den_nxt);
      qneg_r <= (num_r < 0);
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      nlow_r <= {nlow_r[QCAP_W-2:0], 1'b0};
      q_r    <= {q_r[QCAP_W-2:0], ge};
    end
    if (cmd.d_mul) begin
      d_prod_r <= DP_W'(fr_r) * DP_W'(gain_d_r);
    end
    if (cmd.d_rnd) begin
      d_r <= (d_prod_r + D_HALF) >>> F;
    end
    if (cmd.sum) begin
      sum_r <= SUM_W'(p_r) + SUM_W'(integral_r) + SUM_W'(d_r);
    end
    if (cmd.fin) begin
      res_sat_r <= ovf;
      if (ovf) begin
        res_drive_r <= (sum_r < 0) ? W'(-lim_s) : W'(lim_s);
      end else begin
        res_drive_r <= sum_r[W-1:0];
      end
    end
    if (cmd.clear) begin
      res_drive_r <= '0;
      res_sat_r   <= 1'b0;
    end
    if (cmd.load_out) begin
      out_drive_r <= res_drive_r;
      out_sat_r   <= res_sat_r;
    end
  end

  assign sts           = '{clear_req: in_command[1],
                           d_en:      (gain_d_r != '0) && (dt_r != '0)};
  assign out_drive     = out_drive_r;
  assign out_saturated = out_sat_r;

endmodule

// ----- design/pid_filtered_derivative_clamp_core.sv -----
// ----------------------------------------------------------------------------
// pid_filtered_derivative_clamp_core
// PID update step with a low-pass filtered derivative and a clamped output.
// ----------------------------------------------------------------------------
// One input beat at a time is processed. A derivative update runs the
// multiplies, the integral step, the bit-serial divider that forms the filter
// increment, the filter update and the derivative product, then the sum and
// clamp; with the derivative gain or time step at zero the divider and
// derivative steps are skipped. The result sits in an output register, so the
// next input beat is taken while it waits. Configuration is written through the
// plain write port, only while the core is idle: a user rule, not enforced.
module pid_filtered_derivative_clamp_core #(
  parameter int VALUE_WIDTH   = pfdc_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = pfdc_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [pfdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [((VALUE_WIDTH > pfdc_pkg::DT_W) ? VALUE_WIDTH : pfdc_pkg::DT_W)-1:0]
                                         cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pfdc_pkg::CMD_W-1:0]     in_command,
  input  logic signed [VALUE_WIDTH-1:0]  in_setpoint,
  input  logic signed [VALUE_WIDTH-1:0]  in_measured,
  input  logic signed [VALUE_WIDTH-1:0]  in_measured_rate,
  input  logic [pfdc_pkg::DT_W-1:0]      in_time_step,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [VALUE_WIDTH-1:0]  out_drive,
  output logic                           out_saturated
);
  import pfdc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequencer.
  pfdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  pfdc_datapath #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_command),
    .in_setpoint      (in_setpoint),
    .in_measured      (in_measured),
    .in_measured_rate (in_measured_rate),
    .in_time_step     (in_time_step),
    .out_drive        (out_drive),
    .out_saturated    (out_saturated),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
